@@ hdl/hsv_to_rgb_converter_assert.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent check macros that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("HSV to RGB converter: implication check failed");
// The consequent must hold after the antecedent, delayed by the dly argument.
`define HSV_ASSERT_DELAY(label, clk, rst, ante, cons, dly) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("HSV to RGB converter: delayed check failed");
`else
`define HSV_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HSV_ASSERT_DELAY(label, clk, rst, ante, cons, dly)
`endif
`endif

@@ hdl/hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, hue constants and the control word shared by the stages.
// ----------------------------------------------------------------------------
package hsv_pkg;

   // Port field widths.
   localparam int HUE_W      = 17;
   localparam int FRACTION_W = 17;
   localparam int CH_W       = 8;

   // Remainder of the hue within one sector: below 60 degrees in Q9.8.
   localparam int REM_W = 14;

   // One sector is 60 degrees, 360 degrees is a full turn (both Q9.8).
   localparam logic [HUE_W-1:0] HUE_SECTOR = 17'd15360;
   localparam logic [HUE_W-1:0] HUE_FULL   = 17'd92160;

   // The sector width factors as HUE_SECTOR_ODD * 2**HUE_SECTOR_POW2.
   localparam int HUE_SECTOR_POW2 = 10;
   localparam int HUE_SECTOR_ODD  = 15;

   // Colour wheel sector of the hue.
   typedef enum logic [2:0] {
      SECTOR_0,
      SECTOR_1,
      SECTOR_2,
      SECTOR_3,
      SECTOR_4,
      SECTOR_5
   } sector_type;

   // Control word that travels alongside the data through every stage.
   typedef struct packed {
      logic       valid;
      logic       grey;
      sector_type sector;
   } ctrl_type;

endpackage

@@ hdl/hsv_sector_unit.sv @@
// ----------------------------------------------------------------------------
// HSV sector unit
// Three stages: clamps the fractions, finds the hue sector, and divides the
// remainder by the sector width to give the fraction within the sector.
// ----------------------------------------------------------------------------
module hsv_sector_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [hsv_pkg::HUE_W-1:0]        hue,
   input  logic [hsv_pkg::FRACTION_W-1:0]   saturation,
   input  logic [hsv_pkg::FRACTION_W-1:0]   brightness,
   output hsv_pkg::ctrl_type                ctrl_out,
   output logic [FRAC_BITS:0]               sat_out,
   output logic [FRAC_BITS:0]               bri_out,
   output logic [FRAC_BITS-1:0]             frac_out
);
   import hsv_pkg::*;

   localparam int FW = FRAC_BITS + 1;
   localparam int CW = (FRAC_BITS + 2 > FRACTION_W + 1) ? FRAC_BITS + 2 : FRACTION_W + 1;
   localparam int YW = FRAC_BITS + 4;
   localparam int PW = YW + FW;

   localparam logic [CW-1:0] ONE_WIDE = CW'(1) << FRAC_BITS;
   localparam logic [FW-1:0] FIX_ONE  = FW'(1) << FRAC_BITS;
   // Reciprocal of the odd factor, rounded down; the estimate is low by at most one.
   localparam logic [FW-1:0] RECIP    =
      FW'((64'd1 << (FRAC_BITS + 4)) / HUE_SECTOR_ODD);

   // Stage A signals.
   logic [HUE_W-1:0]  hue_wrap;
   logic [HUE_W-1:0]  sector_base;
   sector_type        sector;
   ctrl_type          ctrl_a_in, ctrl_a_ff;
   logic [REM_W-1:0]  rem_a_in, rem_a_ff;
   logic [FW-1:0]     sat_a_in, sat_a_ff;
   logic [FW-1:0]     bri_a_in, bri_a_ff;

   // Stage B signals.
   logic [YW-1:0]        y_b;
   logic [PW-1:0]        prod_b;
   ctrl_type             ctrl_b_ff;
   logic [YW-1:0]        y_b_ff;
   logic [FRAC_BITS-1:0] est_b_in, est_b_ff;
   logic [FW-1:0]        sat_b_ff, bri_b_ff;

   // Stage C signals.
   logic [YW-1:0]        back_c;
   logic [YW-1:0]        resid_c;
   logic [FRAC_BITS-1:0] frac_c_in, frac_c_ff;
   ctrl_type             ctrl_c_ff;
   logic [FW-1:0]        sat_c_ff, bri_c_ff;

   // Stage A: wrap the hue, pick the sector and clamp both fractions to one.
   always_comb begin
      hue_wrap = (hue >= HUE_FULL) ? '0 : hue;
      if (hue_wrap < HUE_SECTOR) begin
         sector = SECTOR_0;
      end else if (hue_wrap < HUE_W'(2 * HUE_SECTOR)) begin
         sector = SECTOR_1;
      end else if (hue_wrap < HUE_W'(3 * HUE_SECTOR)) begin
         sector = SECTOR_2;
      end else if (hue_wrap < HUE_W'(4 * HUE_SECTOR)) begin
         sector = SECTOR_3;
      end else if (hue_wrap < HUE_W'(5 * HUE_SECTOR)) begin
         sector = SECTOR_4;
      end else begin
         sector = SECTOR_5;
      end
      case (sector)
         SECTOR_0: sector_base = '0;
         SECTOR_1: sector_base = HUE_SECTOR;
         SECTOR_2: sector_base = HUE_W'(2 * HUE_SECTOR);
         SECTOR_3: sector_base = HUE_W'(3 * HUE_SECTOR);
         SECTOR_4: sector_base = HUE_W'(4 * HUE_SECTOR);
         SECTOR_5: sector_base = HUE_W'(5 * HUE_SECTOR);
         default:  sector_base = '0;
      endcase
      rem_a_in = REM_W'(hue_wrap - sector_base);
      sat_a_in = (CW'(saturation) > ONE_WIDE) ? FIX_ONE : FW'(saturation);
      bri_a_in = (CW'(brightness) > ONE_WIDE) ? FIX_ONE : FW'(brightness);
      ctrl_a_in.valid  = in_valid;
      ctrl_a_in.grey   = (sat_a_in == '0);
      ctrl_a_in.sector = sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
      end else begin
         ctrl_a_ff <= ctrl_a_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_a_ff <= rem_a_in;
      sat_a_ff <= sat_a_in;
      bri_a_ff <= bri_a_in;
   end

   // Stage B: scale the remainder so that dividing by the odd factor gives
   // the fraction, and estimate that quotient by the reciprocal.
   if (FRAC_BITS >= HUE_SECTOR_POW2) begin : g_scale_up
      assign y_b = YW'(rem_a_ff) << (FRAC_BITS - HUE_SECTOR_POW2);
   end else begin : g_scale_down
      assign y_b = YW'(rem_a_ff >> (HUE_SECTOR_POW2 - FRAC_BITS));
   end

   always_comb begin
      prod_b   = PW'(y_b) * PW'(RECIP);
      est_b_in = prod_b[YW +: FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_b_ff <= '0;
      end else begin
         ctrl_b_ff <= ctrl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      y_b_ff   <= y_b;
      est_b_ff <= est_b_in;
      sat_b_ff <= sat_a_ff;
      bri_b_ff <= bri_a_ff;
   end

   // Stage C: correct the estimate by one where the residue is still too big.
   always_comb begin
      back_c    = YW'(est_b_ff) * YW'(HUE_SECTOR_ODD);
      resid_c   = y_b_ff - back_c;
      frac_c_in = (resid_c >= YW'(HUE_SECTOR_ODD)) ? est_b_ff + FRAC_BITS'(1) : est_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_c_ff <= '0;
      end else begin
         ctrl_c_ff <= ctrl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      frac_c_ff <= frac_c_in;
      sat_c_ff  <= sat_b_ff;
      bri_c_ff  <= bri_b_ff;
   end

   assign ctrl_out = ctrl_c_ff;
   assign sat_out  = sat_c_ff;
   assign bri_out  = bri_c_ff;
   assign frac_out = frac_c_ff;

endmodule

@@ hdl/hsv_term_unit.sv @@
// ----------------------------------------------------------------------------
// HSV term unit
// Two stages of fixed-point products that form the p, q and t terms.
// ----------------------------------------------------------------------------
module hsv_term_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hsv_pkg::ctrl_type     ctrl_in,
   input  logic [FRAC_BITS:0]    sat_in,
   input  logic [FRAC_BITS:0]    bri_in,
   input  logic [FRAC_BITS-1:0]  frac_in,
   output hsv_pkg::ctrl_type     ctrl_out,
   output logic [FRAC_BITS:0]    bri_out,
   output logic [FRAC_BITS:0]    p_out,
   output logic [FRAC_BITS:0]    q_out,
   output logic [FRAC_BITS:0]    t_out
);
   import hsv_pkg::*;

   localparam int FW = FRAC_BITS + 1;
   localparam int MW = 2 * FW;
   localparam logic [FW-1:0] FIX_ONE = FW'(1) << FRAC_BITS;

   // Stage D signals.
   logic [MW-1:0] sff_prod, sfc_prod, p_prod;
   ctrl_type      ctrl_d_ff;
   logic [FW-1:0] sff_d_ff, sfc_d_ff, p_d_ff, bri_d_ff;

   // Stage E signals.
   logic [MW-1:0] q_prod, t_prod;
   ctrl_type      ctrl_e_ff;
   logic [FW-1:0] q_e_ff, t_e_ff, p_e_ff, bri_e_ff;

   // Stage D: s * ff, s * (1 - ff) and p = v * (1 - s).
   always_comb begin
      sff_prod = MW'(sat_in) * MW'(frac_in);
      sfc_prod = MW'(sat_in) * MW'(FIX_ONE - FW'(frac_in));
      p_prod   = MW'(bri_in) * MW'(FIX_ONE - sat_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_d_ff <= '0;
      end else begin
         ctrl_d_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      sff_d_ff <= sff_prod[FRAC_BITS +: FW];
      sfc_d_ff <= sfc_prod[FRAC_BITS +: FW];
      p_d_ff   <= p_prod[FRAC_BITS +: FW];
      bri_d_ff <= bri_in;
   end

   // Stage E: q = v * (1 - s * ff) and t = v * (1 - s * (1 - ff)).
   always_comb begin
      q_prod = MW'(bri_d_ff) * MW'(FIX_ONE - sff_d_ff);
      t_prod = MW'(bri_d_ff) * MW'(FIX_ONE - sfc_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_e_ff <= '0;
      end else begin
         ctrl_e_ff <= ctrl_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_e_ff   <= q_prod[FRAC_BITS +: FW];
      t_e_ff   <= t_prod[FRAC_BITS +: FW];
      p_e_ff   <= p_d_ff;
      bri_e_ff <= bri_d_ff;
   end

   assign ctrl_out = ctrl_e_ff;
   assign bri_out  = bri_e_ff;
   assign p_out    = p_e_ff;
   assign q_out    = q_e_ff;
   assign t_out    = t_e_ff;

endmodule

@@ hdl/hsv_channel_unit.sv @@
// ----------------------------------------------------------------------------
// HSV channel unit
// Routes the terms to red, green and blue by sector and scales each channel
// to its full-scale value into the result registers.
// ----------------------------------------------------------------------------
module hsv_channel_unit #(
   parameter int FRAC_BITS   = 16,
   parameter int CHANNEL_MAX = 255
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hsv_pkg::ctrl_type           ctrl_in,
   input  logic [FRAC_BITS:0]          bri_in,
   input  logic [FRAC_BITS:0]          p_in,
   input  logic [FRAC_BITS:0]          q_in,
   input  logic [FRAC_BITS:0]          t_in,
   output logic                        out_strobe,
   output logic [hsv_pkg::CH_W-1:0]    out_red,
   output logic [hsv_pkg::CH_W-1:0]    out_green,
   output logic [hsv_pkg::CH_W-1:0]    out_blue
);
   import hsv_pkg::*;

   localparam int FW  = FRAC_BITS + 1;
   localparam int CMW = $clog2(CHANNEL_MAX + 1);
   localparam int PW  = (FW + CMW > FRAC_BITS + CH_W) ? FW + CMW : FRAC_BITS + CH_W;

   logic [FW-1:0]   red_sel, green_sel, blue_sel;
   logic            strobe_ff;
   logic [CH_W-1:0] red_in, green_in, blue_in;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;

   // Full-scale multiply, truncated and kept to the low channel bits.
   function automatic logic [CH_W-1:0] to_channel(input logic [FW-1:0] x);
      logic [PW-1:0] prod;
      prod = PW'(x) * PW'(CHANNEL_MAX);
      return prod[FRAC_BITS +: CH_W];
   endfunction

   // Sector routing; a grey pixel takes the value on all three channels.
   always_comb begin
      case (ctrl_in.sector)
         SECTOR_0: begin
            red_sel = bri_in; green_sel = t_in;   blue_sel = p_in;
         end
         SECTOR_1: begin
            red_sel = q_in;   green_sel = bri_in; blue_sel = p_in;
         end
         SECTOR_2: begin
            red_sel = p_in;   green_sel = bri_in; blue_sel = t_in;
         end
         SECTOR_3: begin
            red_sel = p_in;   green_sel = q_in;   blue_sel = bri_in;
         end
         SECTOR_4: begin
            red_sel = t_in;   green_sel = p_in;   blue_sel = bri_in;
         end
         default: begin
            red_sel = bri_in; green_sel = p_in;   blue_sel = q_in;
         end
      endcase
      if (ctrl_in.grey) begin
         red_sel   = bri_in;
         green_sel = bri_in;
         blue_sel  = bri_in;
      end
      red_in   = to_channel(red_sel);
      green_in = to_channel(green_sel);
      blue_in  = to_channel(blue_sel);
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_strobe = strobe_ff;
   assign out_red    = red_ff;
   assign out_green  = green_ff;
   assign out_blue   = blue_ff;

endmodule

@@ hdl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline that turns one HSV pixel into 8-bit red, green, blue.
// ----------------------------------------------------------------------------
// A pixel is taken whenever start is high and busy is low; busy is high only
// while reset is applied, so one transaction can be issued every clock cycle.
// Each result appears on the rsp_ ports for a single cycle, flagged by
// rsp_strobe, after its request has passed one register each for the
// sector search, the reciprocal estimate, its correction, the two product
// stages and the channel scaling. Results come out in request order
// and must be captured when strobed, as there is no way to hold them off.
// Hue is Q9.8 degrees, and 360 degrees or more is read as zero; saturation
// and brightness count 2**FRAC_BITS as one and are clamped to one.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter #(
   parameter int FRAC_BITS   = 16,
   parameter int CHANNEL_MAX = 255
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [hsv_pkg::HUE_W-1:0]        req_hue,
   input  logic [hsv_pkg::FRACTION_W-1:0]   req_saturation,
   input  logic [hsv_pkg::FRACTION_W-1:0]   req_brightness,
   output logic                             rsp_strobe,
   output logic [hsv_pkg::CH_W-1:0]         rsp_red,
   output logic [hsv_pkg::CH_W-1:0]         rsp_green,
   output logic [hsv_pkg::CH_W-1:0]         rsp_blue
);
   import hsv_pkg::*;

   localparam int LATENCY = 6;

   logic                 accept;
   ctrl_type             sec_ctrl, term_ctrl;
   logic [FRAC_BITS:0]   sec_sat, sec_bri;
   logic [FRAC_BITS-1:0] sec_frac;
   logic [FRAC_BITS:0]   term_bri, term_p, term_q, term_t;

   // The pipeline never stalls; requests are refused only during reset.
   assign busy   = reset;
   assign accept = start & ~busy;

   // Sector and fraction within the sector.
   hsv_sector_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .ctrl_out   (sec_ctrl),
      .sat_out    (sec_sat),
      .bri_out    (sec_bri),
      .frac_out   (sec_frac)
   );

   // The p, q and t terms.
   hsv_term_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_term (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (sec_ctrl),
      .sat_in   (sec_sat),
      .bri_in   (sec_bri),
      .frac_in  (sec_frac),
      .ctrl_out (term_ctrl),
      .bri_out  (term_bri),
      .p_out    (term_p),
      .q_out    (term_q),
      .t_out    (term_t)
   );

   // Channel routing, scaling and result registers.
   hsv_channel_unit #(
      .FRAC_BITS   (FRAC_BITS),
      .CHANNEL_MAX (CHANNEL_MAX)
   ) u_channel (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (term_ctrl),
      .bri_in     (term_bri),
      .p_in       (term_p),
      .q_in       (term_q),
      .t_in       (term_t),
      .out_strobe (rsp_strobe),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue)
   );

   // Every accepted transaction yields exactly one strobed result, in order.
   `HSV_ASSERT_DELAY(a_result_follows, clock, reset, accept, rsp_strobe, LATENCY)
   `HSV_ASSERT_IMPLY(a_result_has_request, clock, reset, rsp_strobe, $past(accept, LATENCY))
   // A pixel with zero saturation comes out grey.
   `HSV_ASSERT_IMPLY(a_grey_pixel, clock, reset,
                     rsp_strobe && $past(accept && req_saturation == '0, LATENCY),
                     rsp_red == rsp_green && rsp_green == rsp_blue)

endmodule

@@ dv/hsv_to_rgb_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives HSV pixels with random gaps, has each red/green/blue result typed in
// or predicted in fixed point, checks every strobed one in order, by field.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

   import hsv_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int CHANNEL_MAX = 255;
   localparam logic [63:0] FIX_ONE = 64'd1 << FRAC_BITS;

   localparam int N_RANDOM   = 1850;
   localparam int MAX_GAP    = 6;
   localparam int DRAIN_WAIT = 10;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_pixel_type;

   // One directed transaction; the result is typed in where known is set.
   typedef struct packed {
      logic [HUE_W-1:0]      hue;
      logic [FRACTION_W-1:0] saturation;
      logic [FRACTION_W-1:0] brightness;
      logic                  known;
      rgb_pixel_type         pixel;
   } pixel_row_type;

   localparam int N_DIRECTED = 24;

   pixel_row_type directed_rows [N_DIRECTED] = '{
      // Grey when saturation is zero, with brightness clamped above one.
      '{17'd0,      17'd0,      17'd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
      '{17'd0,      17'd0,      17'd65536,  1'b1, '{8'd255, 8'd255, 8'd255}},
      '{17'd0,      17'd0,      17'd32768,  1'b1, '{8'd127, 8'd127, 8'd127}},
      '{17'd0,      17'd0,      17'd131071, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{17'd131071, 17'd0,      17'd65536,  1'b1, '{8'd255, 8'd255, 8'd255}},
      // Fully saturated primaries and secondaries at each sector start.
      '{17'd0,      17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
      '{17'd15360,  17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd255, 8'd0}},
      '{17'd30720,  17'd65536,  17'd65536,  1'b1, '{8'd0,   8'd255, 8'd0}},
      '{17'd46080,  17'd65536,  17'd65536,  1'b1, '{8'd0,   8'd255, 8'd255}},
      '{17'd61440,  17'd65536,  17'd65536,  1'b1, '{8'd0,   8'd0,   8'd255}},
      '{17'd76800,  17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd255}},
      // A full turn or more reads as hue zero, and fractions above one clamp.
      '{17'd92160,  17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
      '{17'd131071, 17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
      '{17'd0,      17'd131071, 17'd131071, 1'b1, '{8'd255, 8'd0,   8'd0}},
      // Sector ends, mid-sector fractions and other corners.
      '{17'd15359,  17'd65536,  17'd65536,  1'b0, '0},
      '{17'd92159,  17'd65536,  17'd65536,  1'b0, '0},
      '{17'd7680,   17'd32768,  17'd65536,  1'b0, '0},
      '{17'd38400,  17'd1,      17'd65536,  1'b0, '0},
      '{17'd53760,  17'd65535,  17'd1,      1'b0, '0},
      '{17'd99999,  17'd40000,  17'd50000,  1'b0, '0},
      '{17'd69120,  17'd65536,  17'd0,      1'b0, '0},
      '{17'd23040,  17'd98304,  17'd65536,  1'b0, '0},
      '{17'd84480,  17'd12345,  17'd54321,  1'b0, '0},
      '{17'd85000,  17'd131071, 17'd65535,  1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [HUE_W-1:0]      req_hue = '0;
   logic [FRACTION_W-1:0] req_saturation = '0;
   logic [FRACTION_W-1:0] req_brightness = '0;
   logic                  rsp_strobe;
   logic [CH_W-1:0]       rsp_red;
   logic [CH_W-1:0]       rsp_green;
   logic [CH_W-1:0]       rsp_blue;

   rgb_pixel_type expected_pixels [$];
   int            mismatch_count = 0;

   always #5 clock = ~clock;

   hsv_to_rgb_converter #(
      .FRAC_BITS   (FRAC_BITS),
      .CHANNEL_MAX (CHANNEL_MAX)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // Fixed-point HSV to RGB: clamp, pick the sector, form p, q and t, scale.
   function automatic rgb_pixel_type hsv_to_rgb_pixel(input logic [HUE_W-1:0] hue,
                                                      input logic [FRACTION_W-1:0] sat,
                                                      input logic [FRACTION_W-1:0] bright);
      logic [63:0]   h, s, v, ff, p, q, t, r, g, b;
      sector_type    sector;
      rgb_pixel_type px;
      h = 64'(hue);
      s = (64'(sat) > FIX_ONE) ? FIX_ONE : 64'(sat);
      v = (64'(bright) > FIX_ONE) ? FIX_ONE : 64'(bright);
      if (s == 0) begin
         r = v;
         g = v;
         b = v;
      end else begin
         if (h >= 64'(HUE_FULL))
            h = 0;
         sector = sector_type'(h / 64'(HUE_SECTOR));
         ff = ((h % 64'(HUE_SECTOR)) << FRAC_BITS) / 64'(HUE_SECTOR);
         p = (v * (FIX_ONE - s)) >> FRAC_BITS;
         q = (v * (FIX_ONE - ((s * ff) >> FRAC_BITS))) >> FRAC_BITS;
         t = (v * (FIX_ONE - ((s * (FIX_ONE - ff)) >> FRAC_BITS))) >> FRAC_BITS;
         case (sector)
            SECTOR_0: begin r = v; g = t; b = p; end
            SECTOR_1: begin r = q; g = v; b = p; end
            SECTOR_2: begin r = p; g = v; b = t; end
            SECTOR_3: begin r = p; g = q; b = v; end
            SECTOR_4: begin r = t; g = p; b = v; end
            default:  begin r = v; g = p; b = q; end
         endcase
      end
      r = (r * CHANNEL_MAX) >> FRAC_BITS;
      g = (g * CHANNEL_MAX) >> FRAC_BITS;
      b = (b * CHANNEL_MAX) >> FRAC_BITS;
      px.red   = r[CH_W-1:0];
      px.green = g[CH_W-1:0];
      px.blue  = b[CH_W-1:0];
      return px;
   endfunction

   // Issue one transaction after an idle gap and record its expected result.
   // Start is left high on acceptance so that back-to-back pixels follow.
   task automatic send_pixel(input int gap,
                             input logic [HUE_W-1:0] hue,
                             input logic [FRACTION_W-1:0] sat,
                             input logic [FRACTION_W-1:0] bright,
                             input logic known,
                             input rgb_pixel_type typed);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bright;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_pixels.push_back(known ? typed : hsv_to_rgb_pixel(hue, sat, bright));
   endtask

   // Hold the sender off until every outstanding result has come back.
   task automatic drain_pixels();
      start <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // Compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      rgb_pixel_type exp_px;
      if (!reset && rsp_strobe) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: red %0d green %0d blue %0d",
                   rsp_red, rsp_green, rsp_blue);
            mismatch_count++;
         end else begin
            exp_px = expected_pixels.pop_front();
            if (rsp_red !== exp_px.red) begin
               $error("red: expected %0d, actual %0d", exp_px.red, rsp_red);
               mismatch_count++;
            end
            if (rsp_green !== exp_px.green) begin
               $error("green: expected %0d, actual %0d", exp_px.green, rsp_green);
               mismatch_count++;
            end
            if (rsp_blue !== exp_px.blue) begin
               $error("blue: expected %0d, actual %0d", exp_px.blue, rsp_blue);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus: the directed table first, then random pixels.
   initial begin
      logic [HUE_W-1:0]      hue;
      logic [FRACTION_W-1:0] sat;
      logic [FRACTION_W-1:0] bright;
      bit                    burst;
      int                    gap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         gap = (i % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
         send_pixel(gap, directed_rows[i].hue, directed_rows[i].saturation,
                    directed_rows[i].brightness, directed_rows[i].known,
                    directed_rows[i].pixel);
      end
      drain_pixels();

      burst = 1'b0;
      for (int n = 0; n < N_RANDOM; n++) begin
         // Alternate stretches of back-to-back pixels with gappy ones.
         if (n % 50 == 0)
            burst = ($urandom_range(0, 2) == 0);
         if (n == N_RANDOM / 2)
            drain_pixels();

         case ($urandom_range(0, 7))
            0:       hue = HUE_W'(HUE_SECTOR * $urandom_range(0, 6)
                                  + $urandom_range(0, 1) - 1);
            1:       hue = HUE_W'($urandom_range(int'(HUE_FULL), 131071));
            default: hue = HUE_W'($urandom_range(0, int'(HUE_FULL) - 1));
         endcase
         case ($urandom_range(0, 9))
            0:       sat = '0;
            1:       sat = FRACTION_W'($urandom_range(0, 131071));
            2:       sat = 17'd65536;
            default: sat = FRACTION_W'($urandom_range(0, 65536));
         endcase
         case ($urandom_range(0, 9))
            0:       bright = FRACTION_W'($urandom_range(0, 131071));
            1:       bright = 17'd65536;
            default: bright = FRACTION_W'($urandom_range(0, 65536));
         endcase

         gap = burst ? 0 : $urandom_range(0, MAX_GAP);
         send_pixel(gap, hue, sat, bright, 1'b0, '0);
      end

      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("hsv_to_rgb_converter test passed");
      else
         $display("hsv_to_rgb_converter test failed");
      $finish;
   end

   // Watchdog against a hung handshake or missing results.
   initial begin
      #2_000_000;
      $display("hsv_to_rgb_converter test failed");
      $finish;
   end

endmodule
